// ===== rtl/frame_free_list_allocator_defines.svh =====
// Assertion macros for the frame free-list allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define FFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define FFLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/ffla_pkg.sv =====
// Package for the frame free-list allocator: sizes, codes, item types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffla_pkg;

  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned FRAME_W    = $clog2(NUM_FRAMES);
  localparam int unsigned CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned VID_W      = 32;
  localparam int unsigned OWNER_W    = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_YIELD = 1'b1
  } ffla_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } ffla_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_UNLINK,
    S_RESP
  } ffla_state_e;

  typedef struct packed {
    ffla_op_e           op;
    logic [VID_W-1:0]   vid;
    logic [OWNER_W-1:0] owner_process;
  } ffla_in_t;

  typedef struct packed {
    ffla_status_e       status;
    logic [FRAME_W-1:0] frame_id;
  } ffla_out_t;

  // Access request to one simple dual-port RAM.
  typedef struct packed {
    logic               re;
    logic [FRAME_W-1:0] raddr;
    logic               we;
    logic [FRAME_W-1:0] waddr;
  } ffla_port_t;

  // Commands to the free stack.
  typedef struct packed {
    logic               restart;
    logic               pop;
    logic               push;
    logic [FRAME_W-1:0] push_frame;
  } ffla_stack_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ffla_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffla_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/ffla_free_stack.sv =====
// Free-frame stack: RAM, fill count and per-entry written bits.
// Depends on ffla_pkg and ffla_ram.
`timescale 1ns / 1ps
`default_nettype none
module ffla_free_stack (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffla_pkg::ffla_stack_cmd_t     cmd_i,
  input  wire logic [ffla_pkg::CFG_W-1:0]    cfg_data_i,
  output logic      [ffla_pkg::CNT_W-1:0]    free_cnt_o,
  output logic      [ffla_pkg::FRAME_W-1:0]  pop_frame_o
);

  import ffla_pkg::*;

  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NUM_FRAMES-1:0] valid_q, valid_d;
  logic                  rd_valid_q, rd_valid_d;
  logic [FRAME_W-1:0]    dflt_q, dflt_d;
  logic [FRAME_W-1:0]    raddr, waddr;
  logic [CNT_W-1:0]      dflt_full;
  logic [FRAME_W-1:0]    ram_rdata;

  assign raddr     = cnt_q[FRAME_W-1:0] - FRAME_W'(1);
  assign waddr     = cnt_q[FRAME_W-1:0];
  // Unwritten entry i holds frame n-1-i, as after restart.
  assign dflt_full = n_q - CNT_W'(1) - CNT_W'(raddr);

  always_comb begin
    n_d        = n_q;
    cnt_d      = cnt_q;
    valid_d    = valid_q;
    rd_valid_d = rd_valid_q;
    dflt_d     = dflt_q;
    if (cmd_i.restart) begin
      n_d     = (cfg_data_i > CFG_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : CNT_W'(cfg_data_i);
      cnt_d   = n_d;
      valid_d = '0;
    end else if (cmd_i.pop) begin
      cnt_d      = cnt_q - CNT_W'(1);
      rd_valid_d = valid_q[raddr];
      dflt_d     = dflt_full[FRAME_W-1:0];
    end else if (cmd_i.push) begin
      cnt_d          = cnt_q + CNT_W'(1);
      valid_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= CNT_W'(NUM_FRAMES);
      cnt_q      <= CNT_W'(NUM_FRAMES);
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      dflt_q     <= '0;
    end else begin
      n_q        <= n_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
      rd_valid_q <= rd_valid_d;
      dflt_q     <= dflt_d;
    end
  end

  ffla_ram #(
    .Depth (NUM_FRAMES),
    .Width (FRAME_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && !cmd_i.restart),
    .waddr_i (waddr),
    .wdata_i (cmd_i.push_frame),
    .re_i    (cmd_i.pop && !cmd_i.restart),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign free_cnt_o  = cnt_q;
  assign pop_frame_o = rd_valid_q ? ram_rdata : dflt_q;

endmodule
`default_nettype wire

// ===== rtl/ffla_ctrl.sv =====
// Sequencer: allocate, used-list walk, unlink, result register.
// Depends on ffla_pkg; drives the list RAMs and the free stack.
`timescale 1ns / 1ps
`default_nettype none
module ffla_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ffla_pkg::ffla_in_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ffla_pkg::ffla_out_t                out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ffla_pkg::CNT_W-1:0]    free_cnt_i,
  input  wire logic [ffla_pkg::FRAME_W-1:0]  pop_frame_i,
  output ffla_pkg::ffla_stack_cmd_t          stack_cmd_o,
  output ffla_pkg::ffla_port_t               next_port_o,
  output logic      [ffla_pkg::FRAME_W-1:0]  next_wdata_o,
  input  wire logic [ffla_pkg::FRAME_W-1:0]  next_rdata_i,
  output ffla_pkg::ffla_port_t               prev_port_o,
  output logic      [ffla_pkg::FRAME_W-1:0]  prev_wdata_o,
  input  wire logic [ffla_pkg::FRAME_W-1:0]  prev_rdata_i,
  output ffla_pkg::ffla_port_t               vid_port_o,
  output logic      [ffla_pkg::VID_W-1:0]    vid_wdata_o,
  input  wire logic [ffla_pkg::VID_W-1:0]    vid_rdata_i
);

  import ffla_pkg::*;

  ffla_state_e        state_q, state_d;
  logic [VID_W-1:0]   key_q, key_d;
  logic [FRAME_W-1:0] cur_q, cur_d;
  logic [FRAME_W-1:0] nxt_q, nxt_d;
  logic [CNT_W-1:0]   step_q, step_d;
  logic [FRAME_W-1:0] oldest_q, oldest_d;
  logic [FRAME_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0]   used_cnt_q, used_cnt_d;
  ffla_out_t          res_q, res_d;
  ffla_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic in_fire, cfg_fire, slot_free, hit, last_step, no_free, pool_full;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign hit         = (vid_rdata_i == key_q);
  assign last_step   = (CNT_W'(step_q + CNT_W'(1)) == used_cnt_q);
  assign no_free     = (free_cnt_i == '0);
  assign pool_full   = (free_cnt_i == CNT_W'(NUM_FRAMES));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item_i.op == OP_ALLOC) begin
            state_d = no_free ? S_RESP : S_ALLOC;
          end else begin
            state_d = (used_cnt_q == '0 || pool_full) ? S_RESP : S_WALK;
          end
        end
      end
      S_ALLOC:  state_d = S_RESP;
      S_WALK: begin
        if (hit) begin
          state_d = S_UNLINK;
        end else if (last_step) begin
          state_d = S_RESP;
        end
      end
      S_UNLINK: state_d = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    key_d        = key_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    step_d       = step_q;
    oldest_d     = oldest_q;
    newest_d     = newest_q;
    used_cnt_d   = used_cnt_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    stack_cmd_o  = '0;
    next_port_o  = '0;
    prev_port_o  = '0;
    vid_port_o   = '0;
    next_wdata_o = '0;
    prev_wdata_o = '0;
    vid_wdata_o  = key_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          stack_cmd_o.restart = 1'b1;
          oldest_d   = '0;
          newest_d   = '0;
          used_cnt_d = '0;
        end else if (in_fire) begin
          key_d = in_item_i.vid;
          // owner_process has no read path; it is not stored.
          if (in_item_i.op == OP_ALLOC) begin
            if (no_free) begin
              res_d.status   = ST_EMPTY;
              res_d.frame_id = '0;
            end else begin
              stack_cmd_o.pop = 1'b1;
            end
          end else if (used_cnt_q == '0 || pool_full) begin
            res_d.status   = ST_NOT_FOUND;
            res_d.frame_id = '0;
          end else begin
            cur_d             = oldest_q;
            step_d            = '0;
            vid_port_o.re     = 1'b1;
            vid_port_o.raddr  = oldest_q;
            next_port_o.re    = 1'b1;
            next_port_o.raddr = oldest_q;
          end
        end
      end
      S_ALLOC: begin
        vid_port_o.we    = 1'b1;
        vid_port_o.waddr = pop_frame_i;
        if (used_cnt_q != '0) begin
          next_port_o.we    = 1'b1;
          next_port_o.waddr = newest_q;
          next_wdata_o      = pop_frame_i;
          prev_port_o.we    = 1'b1;
          prev_port_o.waddr = pop_frame_i;
          prev_wdata_o      = newest_q;
        end else begin
          oldest_d = pop_frame_i;
        end
        newest_d       = pop_frame_i;
        used_cnt_d     = used_cnt_q + CNT_W'(1);
        res_d.status   = ST_OK;
        res_d.frame_id = pop_frame_i;
      end
      S_WALK: begin
        if (hit) begin
          nxt_d             = next_rdata_i;
          prev_port_o.re    = 1'b1;
          prev_port_o.raddr = cur_q;
        end else if (last_step) begin
          res_d.status   = ST_NOT_FOUND;
          res_d.frame_id = '0;
        end else begin
          cur_d             = next_rdata_i;
          step_d            = step_q + CNT_W'(1);
          vid_port_o.re     = 1'b1;
          vid_port_o.raddr  = next_rdata_i;
          next_port_o.re    = 1'b1;
          next_port_o.raddr = next_rdata_i;
        end
      end
      S_UNLINK: begin
        if (cur_q == oldest_q) begin
          oldest_d = nxt_q;
        end else begin
          next_port_o.we    = 1'b1;
          next_port_o.waddr = prev_rdata_i;
          next_wdata_o      = nxt_q;
        end
        if (cur_q == newest_q) begin
          newest_d = prev_rdata_i;
        end else begin
          prev_port_o.we    = 1'b1;
          prev_port_o.waddr = nxt_q;
          prev_wdata_o      = prev_rdata_i;
        end
        used_cnt_d = used_cnt_q - CNT_W'(1);
        if (used_cnt_q == CNT_W'(1)) begin
          oldest_d = '0;
          newest_d = '0;
        end
        stack_cmd_o.push       = 1'b1;
        stack_cmd_o.push_frame = cur_q;
        res_d.status           = ST_OK;
        res_d.frame_id         = cur_q;
      end
      S_RESP: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      newest_q    <= '0;
      used_cnt_q  <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      used_cnt_q  <= used_cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cur_q <= cur_d;
    nxt_q <= nxt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/frame_free_list_allocator.sv =====
// Top level of the frame free-list allocator: free stack, list RAMs, sequencer.
// Depends on ffla_pkg, ffla_ram, ffla_free_stack, ffla_ctrl and the defines header.
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_item_i): op 0 allocates a frame and
//    binds vid to it; op 1 yields the oldest used frame whose vid matches.
//    Every item gives exactly one result item.
//  - Output channel (out_valid_o/out_ready_i/out_item_o): status and frame_id;
//    errors (free list empty, id not found) return frame_id 0.
//  - Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): frames_in_use. A write
//    restarts the pool with frames 0 upward, frame 0 first; values above 64
//    clamp to 64. Taken only while the sequencer is idle.
//  - Steps: an allocate pops a frame, links it in and then loads the result; an
//    empty pool or empty used list goes straight to the result. A yield walks k used
//    entries (1..64), one per cycle, then unlinks the frame on a match. The next
//    item is taken only once a result has loaded, so items never overlap.
//  - A finished result sits in the output register, so the next item is accepted
//    while the receiver stalls; its result then waits in the sequencer and the
//    input stalls until that register empties.
//  - Reset: 64 frames free, used list empty, no clearing pass; the free stack
//    marks unwritten entries and returns their restart value instead.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_free_list_allocator_defines.svh"
module frame_free_list_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ffla_pkg::ffla_in_t          in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ffla_pkg::ffla_out_t              out_item_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ffla_pkg::CFG_W-1:0]  cfg_data_i
);

  import ffla_pkg::*;

  ffla_stack_cmd_t    stack_cmd;
  logic [CNT_W-1:0]   free_cnt;
  logic [FRAME_W-1:0] pop_frame;

  // Used-list links and per-frame virtual id, each a 1R1W RAM.
  ffla_port_t         next_port, prev_port, vid_port;
  logic [FRAME_W-1:0] next_wdata, next_rdata;
  logic [FRAME_W-1:0] prev_wdata, prev_rdata;
  logic [VID_W-1:0]   vid_wdata, vid_rdata;

  ffla_free_stack u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stack_cmd),
    .cfg_data_i  (cfg_data_i),
    .free_cnt_o  (free_cnt),
    .pop_frame_o (pop_frame)
  );

  ffla_ram #(
    .Depth (NUM_FRAMES),
    .Width (FRAME_W)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_port.we),
    .waddr_i (next_port.waddr),
    .wdata_i (next_wdata),
    .re_i    (next_port.re),
    .raddr_i (next_port.raddr),
    .rdata_o (next_rdata)
  );

  ffla_ram #(
    .Depth (NUM_FRAMES),
    .Width (FRAME_W)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_port.we),
    .waddr_i (prev_port.waddr),
    .wdata_i (prev_wdata),
    .re_i    (prev_port.re),
    .raddr_i (prev_port.raddr),
    .rdata_o (prev_rdata)
  );

  ffla_ram #(
    .Depth (NUM_FRAMES),
    .Width (VID_W)
  ) u_vid_ram (
    .clk_i   (clk_i),
    .we_i    (vid_port.we),
    .waddr_i (vid_port.waddr),
    .wdata_i (vid_wdata),
    .re_i    (vid_port.re),
    .raddr_i (vid_port.raddr),
    .rdata_o (vid_rdata)
  );

  // Writes happen only in the allocate and unlink steps, reads only at accept
  // and during the walk, so no entry is read and written in one cycle.
  ffla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .free_cnt_i   (free_cnt),
    .pop_frame_i  (pop_frame),
    .stack_cmd_o  (stack_cmd),
    .next_port_o  (next_port),
    .next_wdata_o (next_wdata),
    .next_rdata_i (next_rdata),
    .prev_port_o  (prev_port),
    .prev_wdata_o (prev_wdata),
    .prev_rdata_i (prev_rdata),
    .vid_port_o   (vid_port),
    .vid_wdata_o  (vid_wdata),
    .vid_rdata_i  (vid_rdata)
  );

  // Assertions.
  `FFLA_ASSERT_ALWAYS(a_no_cfg_item_overlap, !(in_valid_i && in_ready_o && cfg_valid_i && cfg_ready_o), "config write and item accepted together")
  `FFLA_ASSERT(a_free_cnt_bound, free_cnt <= CNT_W'(NUM_FRAMES), "free count above pool size")
  `FFLA_ASSERT(a_cfg_restart, (cfg_valid_i && cfg_ready_o && cfg_data_i <= CFG_W'(NUM_FRAMES)) |=> (free_cnt == CNT_W'($past(cfg_data_i))), "free count not restarted by config write")
  `FFLA_ASSERT(a_next_rw_apart, !(next_port.we && next_port.re && next_port.waddr == next_port.raddr), "link RAM read and written at one entry")

endmodule
`default_nettype wire
